/* design/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and helpers of the polygon convexity check.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Default coordinate width in bits.
  localparam int COORD_WIDTH = 16;

  // Sign of one cross product, or of the last nonzero one seen.
  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_t;

  // Running orientation state of one ring.
  typedef struct packed {
    turn_t sign;
    logic  conflict;
  } turn_state_t;

  // Folds one product sign into the ring state. A zero product is skipped.
  function automatic turn_state_t note_turn(turn_state_t st, turn_t s);
    turn_state_t r;
    r = st;
    if (s != TURN_NONE) begin
      if (st.sign != TURN_NONE && st.sign != s) begin
        r.conflict = 1'b1;
      end
      r.sign = s;
    end
    return r;
  endfunction

endpackage

/* design/pcc_if.sv */
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels of the polygon convexity check: vertices in, verdicts
// out.
// ----------------------------------------------------------------------------

// Vertex channel: one polygon vertex per transaction.
interface pcc_vertex_if #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// Result channel: one verdict per ring.
interface pcc_result_if;
  logic valid;
  logic ready;
  logic convex;

  modport source (output valid, convex, input ready);
  modport sink   (input valid, convex, output ready);
endinterface

/* design/polygon_convexity_check.sv */
// ----------------------------------------------------------------------------
// polygon_convexity_check
// Streams polygon vertices in ring order and reports whether the ring is
// convex, from the signs of exact cross products at every vertex.
// ----------------------------------------------------------------------------
// The block takes one vertex per cycle in ring order, with last_vertex set on
// the final vertex, and presents one convex verdict per ring after the final
// vertex has left the product register. A vertex passes an input register, a
// product stage (all six partial products of the middle and wrap-around
// cross products, formed in parallel) and a compare-and-fold stage that
// tracks the sign of the last nonzero product; a new vertex enters every
// cycle unless a final vertex is held behind a verdict that waits unread in
// the result register. Rings of three or fewer vertices are reported convex,
// and collinear vertices are ignored.
// ----------------------------------------------------------------------------
module polygon_convexity_check #(
  parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  pcc_vertex_if.sink   vtx,
  pcc_result_if.source res
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // Stage 1: input register.
  logic   valid1;
  coord_t vx1;
  coord_t vy1;
  logic   last1;

  // Ring position state.
  logic [1:0] seen_count;
  coord_t     first_x, first_y, second_x, second_y;
  coord_t     older_x, older_y, recent_x, recent_y;

  // Stage 2: product register.
  logic  valid2;
  logic  last2;
  logic  mid2;
  logic  wrap2;
  prod_t lhs0, rhs0, lhs1, rhs1, lhs2, rhs2;

  // Ring orientation state.
  pcc_pkg::turn_state_t turn_state;

  // Result register.
  logic res_valid;
  logic res_convex;

  // Pipeline flow control.
  logic out_free, adv1, adv2;

  assign out_free  = !res_valid || res.ready;
  assign adv2      = valid2 && (!last2 || out_free);
  assign adv1      = valid1 && (!valid2 || adv2);
  assign vtx.ready = !valid1 || adv1;

  assign res.valid  = res_valid;
  assign res.convex = res_convex;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (vtx.ready) begin
      valid1 <= vtx.valid;
    end
    if (vtx.valid && vtx.ready) begin
      vx1   <= vtx.vertex_x;
      vy1   <= vtx.vertex_y;
      last1 <= vtx.last_vertex;
    end
  end

  // Coordinate differences of the middle product (older, recent, new) and
  // the two wrap-around products (recent, new, first) and (new, first, second).
  diff_t d_rv_x, d_or_y, d_rv_y, d_or_x;
  diff_t d_vf_x, d_rv_y2, d_vf_y, d_rv_x2;
  diff_t d_fs_x, d_vf_y2, d_fs_y, d_vf_x2;

  always_comb begin
    d_rv_x  = DIFF_W'(recent_x) - DIFF_W'(vx1);
    d_or_y  = DIFF_W'(older_y)  - DIFF_W'(recent_y);
    d_rv_y  = DIFF_W'(recent_y) - DIFF_W'(vy1);
    d_or_x  = DIFF_W'(older_x)  - DIFF_W'(recent_x);
    d_vf_x  = DIFF_W'(vx1)      - DIFF_W'(first_x);
    d_rv_y2 = DIFF_W'(recent_y) - DIFF_W'(vy1);
    d_vf_y  = DIFF_W'(vy1)      - DIFF_W'(first_y);
    d_rv_x2 = DIFF_W'(recent_x) - DIFF_W'(vx1);
    d_fs_x  = DIFF_W'(first_x)  - DIFF_W'(second_x);
    d_vf_y2 = DIFF_W'(vy1)      - DIFF_W'(first_y);
    d_fs_y  = DIFF_W'(first_y)  - DIFF_W'(second_y);
    d_vf_x2 = DIFF_W'(vx1)      - DIFF_W'(first_x);
  end

  // Product stage and ring position update.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2     <= 1'b0;
      seen_count <= 2'd0;
    end else begin
      if (!valid2 || adv2) begin
        valid2 <= adv1;
      end
      if (adv1) begin
        if (last1) begin
          seen_count <= 2'd0;
        end else if (seen_count != 2'd3) begin
          seen_count <= seen_count + 2'd1;
        end
      end
    end
    if (adv1) begin
      last2 <= last1;
      mid2  <= (seen_count >= 2'd2);
      wrap2 <= last1 && (seen_count == 2'd3);
      lhs0  <= d_rv_x * d_or_y;
      rhs0  <= d_rv_y * d_or_x;
      lhs1  <= d_vf_x * d_rv_y2;
      rhs1  <= d_vf_y * d_rv_x2;
      lhs2  <= d_fs_x * d_vf_y2;
      rhs2  <= d_fs_y * d_vf_x2;
      if (seen_count == 2'd0) begin
        first_x <= vx1;
        first_y <= vy1;
      end
      if (seen_count == 2'd1) begin
        second_x <= vx1;
        second_y <= vy1;
      end
      older_x  <= recent_x;
      older_y  <= recent_y;
      recent_x <= vx1;
      recent_y <= vy1;
    end
  end

  // Sign of a product difference.
  function automatic pcc_pkg::turn_t sign_of(prod_t lhs, prod_t rhs);
    pcc_pkg::turn_t s;
    if (lhs > rhs) begin
      s = pcc_pkg::TURN_POS;
    end else if (lhs < rhs) begin
      s = pcc_pkg::TURN_NEG;
    end else begin
      s = pcc_pkg::TURN_NONE;
    end
    return s;
  endfunction

  // Compare stage: fold the signs in ring order.
  pcc_pkg::turn_state_t fold_a, fold_b, fold_c;

  always_comb begin
    fold_a = turn_state;
    if (mid2) begin
      fold_a = pcc_pkg::note_turn(fold_a, sign_of(lhs0, rhs0));
    end
    fold_b = fold_a;
    fold_c = fold_a;
    if (wrap2) begin
      fold_b = pcc_pkg::note_turn(fold_a, sign_of(lhs1, rhs1));
      fold_c = pcc_pkg::note_turn(fold_b, sign_of(lhs2, rhs2));
    end
  end

  // Orientation state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_state <= '{sign: pcc_pkg::TURN_NONE, conflict: 1'b0};
      res_valid  <= 1'b0;
    end else begin
      if (adv2) begin
        if (last2) begin
          turn_state <= '{sign: pcc_pkg::TURN_NONE, conflict: 1'b0};
        end else begin
          turn_state <= fold_c;
        end
      end
      if (adv2 && last2) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (adv2 && last2) begin
      res_convex <= !(wrap2 && fold_c.conflict);
    end
  end

  // A verdict appears only after a final vertex left the compare stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(valid2 && last2))
    else $error("verdict without a final vertex");

  // Wrap-around products are only taken on a final vertex.
  a_wrap_on_last: assert property (@(posedge clk) disable iff (rst)
    valid2 && wrap2 |-> last2 && mid2)
    else $error("wrap-around products on a non-final vertex");

  // A conflict needs a recorded nonzero turn.
  a_conflict_sign: assert property (@(posedge clk) disable iff (rst)
    turn_state.conflict |-> turn_state.sign != pcc_pkg::TURN_NONE)
    else $error("sign conflict with no turn recorded");

  // The input side stalls only while the input register holds a vertex.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !vtx.ready |-> valid1 && valid2)
    else $error("input stalled with an empty pipeline");

endmodule
